@@ src/ina_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and word helpers for the idle number allocator.
// No dependencies; the top level, the word unit and the bench refer to this package.
package ina_pkg;

    localparam int DEF_NUMBERS = 1024;
    localparam int WORD_BITS   = 32;

    // Request opcodes
    localparam logic [2:0] OP_FIND_IDLE = 3'd0;
    localparam logic [2:0] OP_MARK_USED = 3'd1;
    localparam logic [2:0] OP_MARK_FREE = 3'd2;
    localparam logic [2:0] OP_CLEAR_ALL = 3'd3;
    localparam logic [2:0] OP_TRIM      = 3'd4;
    localparam logic [2:0] OP_NEXT_USED = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_FIRST_NUMBER = 2'd0;
    localparam logic [1:0] CFG_MAX_NUMBER   = 2'd1;

    // Control for evaluating one map word
    typedef struct packed {
        logic [2:0] op;
        logic       at_first;
        logic       at_last;
        logic [4:0] start_bit;
        logic [4:0] end_bit;
    } word_ctl_t;

    // Outcome of evaluating one map word
    typedef struct packed {
        logic        done;
        logic        hit;
        logic [4:0]  hit_bit;
        logic        wr_en;
        logic [31:0] wr_word;
        logic        cnt_inc;
        logic [5:0]  cnt_dec;
    } word_eval_t;

    function automatic logic [5:0] pop32(input logic [31:0] w);
        logic [1:0] l1 [16];
        logic [2:0] l2 [8];
        logic [3:0] l3 [4];
        logic [4:0] l4 [2];
        for (int i = 0; i < 16; i++) l1[i] = {1'b0, w[2*i]} + {1'b0, w[2*i+1]};
        for (int i = 0; i < 8; i++)  l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        for (int i = 0; i < 4; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        for (int i = 0; i < 2; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        return {1'b0, l4[0]} + {1'b0, l4[1]};
    endfunction

    function automatic logic [4:0] lowest_set(input logic [31:0] w);
        logic [4:0] idx;
        idx = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (w[i])
            begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ src/idle_number_allocator.sv @@
`timescale 1ns / 1ps
// Idle number allocator: top level with sequencer, counters and output register.
// Depends on ina_pkg, ina_map_ram and ina_word_unit.
//
// Usage:
//   s_axis carries requests {number, opcode}; m_axis returns one response per
//   request {status, used_count, result_number}. cfg writes first_number
//   (index 0) or max_number (index 1); write it only while no request is open.
//   The in-use map lives in a memory of NUMBERS/32+1 words of 32 bits, one
//   word read per cycle through a registered read port.
// Sequencing:
//   One request at a time. A scan request (find idle, next used, trim) walks
//   the map words it covers in order; mark used and mark free evaluate a
//   single word, clear all sweeps every word, and out-of-range and unknown
//   requests go straight to the response.
// Reset:
//   After rst_n releases, a clearing pass writes zeros to all NUMBERS/32+1
//   words while s_axis_tready stays low; cfg writes are taken throughout.
// Stalls:
//   A finished response waits in the output register; the next request is
//   accepted meanwhile and its response holds until m_axis_tready frees it.
module idle_number_allocator #(
    parameter int NUMBERS = ina_pkg::DEF_NUMBERS
) (
    input  logic        clk,
    input  logic        rst_n,
    // request: [2:0] opcode, [13:3] number, [15:14] zero
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    // response: [10:0] result_number, [21:11] used_count, [22] status, [23] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    localparam int WORDS = NUMBERS / ina_pkg::WORD_BITS + 1;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_RESP  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          clr_resp_reg, clr_resp_next;
    logic [10:0]   used_reg, used_next;
    logic [10:0]   first_number_reg;
    logic [10:0]   max_number_reg;
    logic          m_valid_reg, m_valid_next;

    logic [2:0]    op_reg, op_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic          first_reg, first_next;
    logic [AW-1:0] end_word_reg, end_word_next;
    logic [4:0]    start_bit_reg, start_bit_next;
    logic [4:0]    end_bit_reg, end_bit_next;
    logic [10:0]   res_num_reg, res_num_next;
    logic          res_status_reg, res_status_next;
    logic [10:0]   out_num_reg, out_num_next;
    logic [10:0]   out_cnt_reg, out_cnt_next;
    logic          out_status_reg, out_status_next;

    // request decode
    logic [2:0]    in_op;
    logic [10:0]   in_num;
    logic          in_accept;
    logic          num_valid;
    logic [10:0]   find_lo;
    logic [10:0]   find_hi;
    logic [11:0]   start_pos;
    logic [31:0]   start_pos32;
    logic [31:0]   find_hi32;
    logic [AW-1:0] start_word;
    logic [31:0]   hit_pos;

    // memory and word unit
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;
    ina_pkg::word_ctl_t  wctl;
    ina_pkg::word_eval_t wev;

    assign in_op     = s_axis_tdata[2:0];
    assign in_num    = s_axis_tdata[13:3];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign num_valid = (in_num != 11'd0) && (32'(in_num) <= NUMBERS);
    assign find_lo   = (first_number_reg == 11'd0) ? 11'd1 : first_number_reg;
    assign find_hi   = (32'(max_number_reg) < NUMBERS) ? max_number_reg : 11'(NUMBERS);

    // first position that the request touches
    always_comb
    begin
        case (in_op)
            ina_pkg::OP_FIND_IDLE: start_pos = {1'b0, find_lo};
            ina_pkg::OP_NEXT_USED: start_pos = {1'b0, in_num} + 12'd1;
            ina_pkg::OP_TRIM:      start_pos = {1'b0, max_number_reg} + 12'd1;
            default:               start_pos = {1'b0, in_num};
        endcase
    end

    assign start_pos32 = 32'(start_pos);
    assign find_hi32   = 32'(find_hi);
    assign start_word  = start_pos32[AW+4:5];
    assign hit_pos     = (32'(cur_reg) << 5) | 32'(wev.hit_bit);

    assign wctl.op        = op_reg;
    assign wctl.at_first  = first_reg;
    assign wctl.at_last   = (cur_reg == end_word_reg);
    assign wctl.start_bit = start_bit_reg;
    assign wctl.end_bit   = end_bit_reg;

    ina_word_unit u_word (
        .ctl   (wctl),
        .rdata (mem_rdata),
        .ev    (wev)
    );

    ina_map_ram #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // memory ports: clear sweep or write-back of the word under evaluation
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_reg;
        mem_wdata = wev.wr_word;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            mem_we = wev.wr_en;
        end
    end

    // read ahead: next word during a scan, first word while idle
    always_comb
    begin
        if (state_reg == ST_SCAN)
        begin
            mem_raddr = wctl.at_last ? cur_reg : cur_reg + AW'(1);
        end
        else
        begin
            mem_raddr = start_word;
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        clr_resp_next   = clr_resp_reg;
        used_next       = used_reg;
        m_valid_next    = m_valid_reg;
        op_next         = op_reg;
        cur_next        = cur_reg;
        first_next      = first_reg;
        end_word_next   = end_word_reg;
        start_bit_next  = start_bit_reg;
        end_bit_next    = end_bit_reg;
        res_num_next    = res_num_reg;
        res_status_next = res_status_reg;
        out_num_next    = out_num_reg;
        out_cnt_next    = out_cnt_reg;
        out_status_next = out_status_reg;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_WORD)
                begin
                    clr_addr_next = '0;
                    clr_resp_next = 1'b0;
                    state_next    = clr_resp_reg ? ST_RESP : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next         = in_op;
                    cur_next        = start_word;
                    first_next      = 1'b1;
                    end_word_next   = LAST_WORD;
                    start_bit_next  = start_pos[4:0];
                    end_bit_next    = 5'd31;
                    res_num_next    = '0;
                    res_status_next = 1'b0;
                    state_next      = ST_RESP;
                    case (in_op)
                        ina_pkg::OP_FIND_IDLE:
                        begin
                            end_word_next = find_hi32[AW+4:5];
                            end_bit_next  = find_hi[4:0];
                            if (find_lo <= find_hi)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        ina_pkg::OP_MARK_USED,
                        ina_pkg::OP_MARK_FREE:
                        begin
                            end_word_next = start_word;
                            if (num_valid)
                            begin
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                res_status_next = 1'b1;
                            end
                        end
                        ina_pkg::OP_CLEAR_ALL:
                        begin
                            used_next     = '0;
                            clr_addr_next = '0;
                            clr_resp_next = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        ina_pkg::OP_TRIM:
                        begin
                            if (32'(max_number_reg) < NUMBERS)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        ina_pkg::OP_NEXT_USED:
                        begin
                            if (32'(in_num) > NUMBERS)
                            begin
                                res_status_next = 1'b1;
                            end
                            else if (32'(in_num) < NUMBERS)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                used_next  = used_reg + {10'd0, wev.cnt_inc} - {5'd0, wev.cnt_dec};
                cur_next   = cur_reg + AW'(1);
                first_next = 1'b0;
                if (wev.done)
                begin
                    cur_next     = cur_reg;
                    res_num_next = wev.hit ? hit_pos[10:0] : 11'd0;
                    state_next   = ST_RESP;
                end
            end
            ST_RESP:
            begin
                // hold until the output register is free
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next    = 1'b1;
                    out_num_next    = res_num_reg;
                    out_cnt_next    = used_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            clr_resp_reg     <= 1'b0;
            used_reg         <= '0;
            m_valid_reg      <= 1'b0;
            first_number_reg <= 11'd1;
            max_number_reg   <= 11'd0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            clr_resp_reg <= clr_resp_next;
            used_reg     <= used_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ina_pkg::CFG_FIRST_NUMBER: first_number_reg <= cfg_data;
                    ina_pkg::CFG_MAX_NUMBER:   max_number_reg   <= cfg_data;
                    default:                   ;
                endcase
            end
        end
    end

    // request and response payload
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        cur_reg        <= cur_next;
        first_reg      <= first_next;
        end_word_reg   <= end_word_next;
        start_bit_reg  <= start_bit_next;
        end_bit_reg    <= end_bit_next;
        res_num_reg    <= res_num_next;
        res_status_reg <= res_status_next;
        out_num_reg    <= out_num_next;
        out_cnt_reg    <= out_cnt_next;
        out_status_reg <= out_status_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, out_status_reg, out_cnt_reg, out_num_reg};

    // a request leaves the idle state, so the port closes right after it
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_axis_tready)
        else $error("request accepted while another is open");

    // the map never holds more used numbers than it has entries
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[21:11]) <= NUMBERS))
        else $error("used count beyond map size");

    // a flagged request never reports a number
    a_flag_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[22]) |-> (m_axis_tdata[10:0] == 11'd0))
        else $error("out-of-range request returned a number");

    // the map is written only by the clear sweep or a scan write-back
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_SCAN))
        else $error("map write outside clear or scan");

endmodule

@@ src/ina_map_ram.sv @@
`timescale 1ns / 1ps
// In-use map storage: one write port, one registered read port.
// Depends on nothing; sized by the top level.
module ina_map_ram #(
    parameter int WORDS = 33,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [WORDS];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/ina_word_unit.sv @@
`timescale 1ns / 1ps
// Evaluates one 32-bit map word: range mask, priority search, modify, popcount.
// Depends on ina_pkg.
module ina_word_unit (
    input  ina_pkg::word_ctl_t  ctl,
    input  logic [31:0]         rdata,
    output ina_pkg::word_eval_t ev
);

    logic [4:0]  lb;
    logic [4:0]  ub;
    logic [31:0] mask;
    logic [31:0] bit_sel;
    logic [31:0] cand;

    always_comb
    begin
        lb      = ctl.at_first ? ctl.start_bit : 5'd0;
        ub      = ctl.at_last ? ctl.end_bit : 5'd31;
        mask    = ({32{1'b1}} << lb) & ({32{1'b1}} >> (5'd31 - ub));
        bit_sel = 32'd1 << ctl.start_bit;

        case (ctl.op)
            ina_pkg::OP_FIND_IDLE: cand = ~rdata & mask;
            ina_pkg::OP_NEXT_USED: cand = rdata & mask;
            default:               cand = '0;
        endcase

        ev.hit     = |cand;
        ev.hit_bit = ina_pkg::lowest_set(cand);
        ev.done    = 1'b1;
        ev.wr_en   = 1'b0;
        ev.wr_word = rdata;
        ev.cnt_inc = 1'b0;
        ev.cnt_dec = '0;

        case (ctl.op)
            ina_pkg::OP_FIND_IDLE,
            ina_pkg::OP_NEXT_USED:
            begin
                ev.done = ev.hit | ctl.at_last;
            end
            ina_pkg::OP_TRIM:
            begin
                // drop every used bit at or above the start position
                ev.done    = ctl.at_last;
                ev.wr_en   = 1'b1;
                ev.wr_word = rdata & ~mask;
                ev.cnt_dec = ina_pkg::pop32(rdata & mask);
            end
            ina_pkg::OP_MARK_USED:
            begin
                ev.wr_en   = ~|(rdata & bit_sel);
                ev.wr_word = rdata | bit_sel;
                ev.cnt_inc = ~|(rdata & bit_sel);
            end
            ina_pkg::OP_MARK_FREE:
            begin
                ev.wr_en   = |(rdata & bit_sel);
                ev.wr_word = rdata & ~bit_sel;
                ev.cnt_dec = {5'd0, |(rdata & bit_sel)};
            end
            default:
            begin
                ev.done = 1'b1;
            end
        endcase
    end

endmodule

@@ dv/idle_number_allocator_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for idle_number_allocator: random-gapped request driver,
// stalling response monitor and an in-bench copy of the in-use map that predicts
// every response. Depends on ina_pkg and the RTL under src/.
module idle_number_allocator_tb;

    localparam int NUMBERS = ina_pkg::DEF_NUMBERS;

    // Opcodes without a defined action; the block must leave the map alone.
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    // Register index with nothing behind it; a write must change nothing.
    localparam logic [1:0] CFG_SPARE = 2'd3;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned PHASE_SETTLE   = 8;
    localparam int unsigned END_SETTLE     = 40;
    localparam int unsigned RANDOM_PHASES  = 8;
    localparam int unsigned PHASE_ITEMS    = 55;
    localparam int unsigned MAX_REPORTS    = 10;

    // Response fields as packed on m_axis_tdata[22:0]
    typedef struct packed {
        logic        status;
        logic [10:0] used_count;
        logic [10:0] result_number;
    } resp_t;

    typedef struct {
        logic [1:0]  reg_index;
        logic [10:0] value;
    } reg_write_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // [2:0] opcode, [13:3] number, [15:14] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [10:0] result_number, [21:11] used_count, [22] status
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [10:0] cfg_data = '0;

    // Request queue that the driver drains, and responses still owed by the block
    logic [15:0] pending_requests[$];
    resp_t       awaited_responses[$];
    reg_write_t  reg_writes[$];

    // Shadow of the allocator: map (entry 0 unused), used total and limits
    bit [NUMBERS:0] busy_map = '0;
    int unsigned    busy_total = 0;
    logic [10:0]    lim_first = 11'd1;
    logic [10:0]    lim_max = 11'd0;

    // First number being programmed; the stimulus generator aims its numbers with it
    int unsigned plan_first = 1;

    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;

    int unsigned burst_left = 4;
    int unsigned gap_left = 0;
    int unsigned stall_mode = 0;
    int unsigned mode_left = 0;
    int unsigned stall_tick = 0;

    idle_number_allocator #(
        .NUMBERS(NUMBERS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Apply one request to the shadow map and return the response it must get.
    function automatic resp_t apply_request(logic [2:0] op, logic [10:0] num);
        resp_t       r;
        int unsigned lo;
        int unsigned hi;
        int unsigned k;
        bit          in_range;
        r = '0;
        in_range = (num >= 1) && (num <= NUMBERS);
        case (op)
            ina_pkg::OP_FIND_IDLE:
            begin
                // A zero first number still starts the search at 1; the top
                // end is clipped to the map.
                lo = (lim_first < 1) ? 1 : lim_first;
                hi = (lim_max < NUMBERS) ? lim_max : NUMBERS;
                for (k = lo; k <= hi; k++)
                begin
                    if (!busy_map[k])
                    begin
                        r.result_number = 11'(k);
                        break;
                    end
                end
            end
            ina_pkg::OP_MARK_USED:
            begin
                if (!in_range)
                begin
                    r.status = 1'b1;
                end
                else if (!busy_map[num])
                begin
                    busy_map[num] = 1'b1;
                    busy_total++;
                end
            end
            ina_pkg::OP_MARK_FREE:
            begin
                if (!in_range)
                begin
                    r.status = 1'b1;
                end
                else if (busy_map[num])
                begin
                    busy_map[num] = 1'b0;
                    busy_total--;
                end
            end
            ina_pkg::OP_CLEAR_ALL:
            begin
                busy_map = '0;
                busy_total = 0;
            end
            ina_pkg::OP_TRIM:
            begin
                // A bound at or above the map size frees nothing.
                if (lim_max < NUMBERS)
                begin
                    for (k = lim_max + 1; k <= NUMBERS; k++)
                    begin
                        if (busy_map[k])
                        begin
                            busy_map[k] = 1'b0;
                            busy_total--;
                        end
                    end
                end
            end
            ina_pkg::OP_NEXT_USED:
            begin
                // Bound is exclusive; a bound past the map is flagged.
                if (num > NUMBERS)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    for (k = num + 1; k <= NUMBERS; k++)
                    begin
                        if (busy_map[k])
                        begin
                            r.result_number = 11'(k);
                            break;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.used_count = (busy_total > 11'h7FF) ? 11'h7FF : 11'(busy_total);
        return r;
    endfunction

    task automatic note_mismatch(string what, int unsigned want, int unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("mismatch on %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
        end
    endtask

    task automatic queue_request(logic [2:0] op, logic [10:0] num);
        pending_requests.push_back({2'b00, num, op});
    endtask

    // Hold until every queued request has gone out and every response is in,
    // then let the block settle.
    task automatic wait_drained(int unsigned settle);
        @(negedge clk);
        while (pending_requests.size() != 0 || s_axis_tvalid || awaited_responses.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (settle) @(posedge clk);
    endtask

    // Push the queued register writes back to back; valid stays high between them.
    task automatic apply_register_writes();
        reg_write_t w;
        @(posedge clk);
        while (reg_writes.size() != 0)
        begin
            w = reg_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.reg_index;
            cfg_data  <= w.value;
            @(posedge clk);
            while (!cfg_ready)
            begin
                @(posedge clk);
            end
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic program_limits(int unsigned lo, int unsigned hi);
        plan_first = lo;
        reg_writes.push_back('{ina_pkg::CFG_FIRST_NUMBER, 11'(lo)});
        reg_writes.push_back('{ina_pkg::CFG_MAX_NUMBER, 11'(hi)});
        apply_register_writes();
        @(negedge clk);
    endtask

    // Random phase: mostly runs of consecutive marks from the start of the
    // search window, so that find idle and next used walk across many words,
    // mixed with holes, queries, clears, trims, bad numbers and plain noise.
    task automatic queue_random_phase(int unsigned count);
        int unsigned issued;
        int unsigned cursor;
        int unsigned base;
        int unsigned pick;
        int unsigned run;
        int unsigned k;
        issued = 0;
        cursor = 0;
        base = (plan_first >= 1 && plan_first <= NUMBERS) ? plan_first : $urandom_range(1, 64);
        while (issued < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                run = $urandom_range(1, 24);
                for (k = 0; k < run; k++)
                begin
                    queue_request(ina_pkg::OP_MARK_USED, 11'(base + cursor));
                    cursor++;
                end
                issued += run;
            end
            else
            begin
                if (pick < 52)
                begin
                    queue_request(ina_pkg::OP_FIND_IDLE, 11'($urandom_range(0, 2047)));
                end
                else if (pick < 66)
                begin
                    queue_request(ina_pkg::OP_NEXT_USED,
                                  ($urandom_range(0, 3) == 0) ? 11'd0 :
                                  11'(base + $urandom_range(0, cursor + 32)));
                end
                else if (pick < 78)
                begin
                    queue_request(ina_pkg::OP_MARK_FREE,
                                  11'(base + $urandom_range(0, cursor + 8)));
                end
                else if (pick < 81)
                begin
                    queue_request(ina_pkg::OP_CLEAR_ALL, 11'($urandom_range(0, 2047)));
                    cursor = 0;
                end
                else if (pick < 85)
                begin
                    queue_request(ina_pkg::OP_TRIM, 11'($urandom_range(0, 2047)));
                end
                else if (pick < 90)
                begin
                    // Mark with a number outside 1..NUMBERS: flagged, map untouched
                    queue_request(($urandom_range(0, 1) == 0) ? ina_pkg::OP_MARK_USED :
                                  ina_pkg::OP_MARK_FREE,
                                  ($urandom_range(0, 2) == 0) ? 11'd0 :
                                  11'($urandom_range(NUMBERS + 1, 2047)));
                end
                else
                begin
                    queue_request(3'($urandom_range(0, 7)), 11'($urandom_range(0, 2047)));
                end
                issued++;
            end
        end
    endtask

    // Request driver: bursts of random length, random gaps, and now and then
    // a long burst with no gap at all. Hold the request while it is not taken.
    always @(posedge clk)
    begin : request_drive
        logic        next_valid;
        logic [15:0] next_data;
        if (rst_n && !(s_axis_tvalid && !s_axis_tready))
        begin
            next_valid = 1'b0;
            next_data = s_axis_tdata;
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (pending_requests.size() != 0)
            begin
                next_data = pending_requests.pop_front();
                next_valid = 1'b1;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    burst_left = $urandom_range(30, 80);
                    gap_left = 0;
                end
                else
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 30) :
                               $urandom_range(0, 4);
                end
            end
            s_axis_tvalid <= next_valid;
            s_axis_tdata  <= next_data;
        end
    end

    // Response ready: switch at random intervals between a handful of stall
    // patterns, from always ready to long periodic stalls.
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 4);
            mode_left  <= $urandom_range(40, 200);
        end
        else
        begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            3: m_axis_tready <= ((stall_tick % 9) < 4);
            default: m_axis_tready <= ((stall_tick % 24) >= 18);
        endcase
    end

    // Monitor: check each response against the oldest prediction, then
    // predict for a request taken at this edge and track register writes.
    always @(posedge clk)
    begin : response_check
        resp_t seen;
        resp_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            seen = m_axis_tdata[22:0];
            if (awaited_responses.size() == 0)
            begin
                note_mismatch("response with no open request", 0, seen);
            end
            else
            begin
                want = awaited_responses.pop_front();
                if (seen.result_number !== want.result_number)
                begin
                    note_mismatch("result_number", want.result_number, seen.result_number);
                end
                if (seen.used_count !== want.used_count)
                begin
                    note_mismatch("used_count", want.used_count, seen.used_count);
                end
                if (seen.status !== want.status)
                begin
                    note_mismatch("status", want.status, seen.status);
                end
            end
        end
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == ina_pkg::CFG_FIRST_NUMBER)
            begin
                lim_first = cfg_data;
            end
            else if (cfg_index == ina_pkg::CFG_MAX_NUMBER)
            begin
                lim_max = cfg_data;
            end
        end
        if (s_axis_tvalid && s_axis_tready)
        begin
            awaited_responses.push_back(apply_request(s_axis_tdata[2:0], s_axis_tdata[13:3]));
        end
    end

    // Watchdog: drop the run when no channel has moved anything for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int unsigned p;
        int unsigned sel;
        int unsigned lo;
        int unsigned hi;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset limits (first 1, max 0): the find window is empty.
        queue_request(ina_pkg::OP_FIND_IDLE, 11'd0);
        queue_request(ina_pkg::OP_MARK_USED, 11'd0);
        queue_request(ina_pkg::OP_MARK_USED, 11'(NUMBERS));
        queue_request(ina_pkg::OP_MARK_USED, 11'd2047);
        queue_request(ina_pkg::OP_MARK_FREE, 11'(NUMBERS + 1));
        queue_request(ina_pkg::OP_NEXT_USED, 11'd0);
        queue_request(ina_pkg::OP_NEXT_USED, 11'(NUMBERS));
        queue_request(ina_pkg::OP_NEXT_USED, 11'(NUMBERS + 1));
        queue_request(ina_pkg::OP_NEXT_USED, 11'd2047);
        queue_request(OP_SPARE_LO, 11'd5);
        queue_request(OP_SPARE_HI, 11'd2047);
        // Trim with max 0 frees the top number again
        queue_request(ina_pkg::OP_TRIM, 11'd1);
        queue_request(ina_pkg::OP_MARK_USED, 11'd1);
        queue_request(ina_pkg::OP_MARK_USED, 11'd1);
        queue_request(ina_pkg::OP_MARK_FREE, 11'd2);
        queue_request(ina_pkg::OP_CLEAR_ALL, 11'd2047);
        queue_request(ina_pkg::OP_MARK_FREE, 11'd0);
        wait_drained(PHASE_SETTLE);

        // First number zero with a max past the map; poke the spare index too.
        reg_writes.push_back('{CFG_SPARE, 11'h7FF});
        program_limits(0, 2047);
        queue_request(ina_pkg::OP_MARK_USED, 11'd1);
        queue_request(ina_pkg::OP_MARK_USED, 11'd2);
        queue_request(ina_pkg::OP_FIND_IDLE, 11'd7);
        queue_request(ina_pkg::OP_TRIM, 11'd0);
        queue_request(ina_pkg::OP_NEXT_USED, 11'd1);
        wait_drained(PHASE_SETTLE);

        // Window of exactly the top number.
        program_limits(NUMBERS, NUMBERS);
        queue_request(ina_pkg::OP_FIND_IDLE, 11'd0);
        queue_request(ina_pkg::OP_MARK_USED, 11'(NUMBERS));
        queue_request(ina_pkg::OP_FIND_IDLE, 11'd0);
        queue_request(ina_pkg::OP_TRIM, 11'd0);
        wait_drained(PHASE_SETTLE);

        // Random phases: first visit every limit shape once, then pick at random.
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            sel = (p < 6) ? p : $urandom_range(0, 5);
            case (sel)
                0:
                begin
                    lo = 1;
                    hi = NUMBERS;
                end
                1:
                begin
                    lo = $urandom_range(1, 900);
                    hi = lo + $urandom_range(0, 120);
                end
                2:
                begin
                    lo = 0;
                    hi = 2047;
                end
                3:
                begin
                    // first above max: find idle has nowhere to look
                    lo = $urandom_range(2, NUMBERS);
                    hi = $urandom_range(0, lo - 1);
                end
                4:
                begin
                    lo = 2047;
                    hi = $urandom_range(0, 2047);
                end
                default:
                begin
                    lo = $urandom_range(1, 64);
                    hi = $urandom_range(NUMBERS - 64, NUMBERS);
                end
            endcase
            program_limits(lo, hi);
            queue_random_phase(PHASE_ITEMS);
            wait_drained(PHASE_SETTLE);
        end

        wait_drained(END_SETTLE);
        if (mismatches == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
